### src/tcct_pkg.sv
package tcct_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int SLOT_W    = 4;
    localparam int HOURS_W   = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int FRAMES_W  = 5;
    localparam int TIME_W    = HOURS_W + MIN_W + SEC_W + FRAMES_W;
    localparam int CUE_W     = 20;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_ENABLE    = 2'd2,
        OP_ARM_RESET = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               slot_ok;
        logic [SLOT_W-1:0]  slot;
        logic [TIME_W-1:0]  tc;
        logic [CUE_W-1:0]   cue;
        logic               enabled;
    } t_cmd;

endpackage

### src/tcct_if.sv
interface tcct_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcct_pkg::OP_W-1:0]     opcode;
    logic [tcct_pkg::SLOT_W-1:0]   slot;
    logic [tcct_pkg::HOURS_W-1:0]  hours;
    logic [tcct_pkg::MIN_W-1:0]    minutes;
    logic [tcct_pkg::SEC_W-1:0]    seconds;
    logic [tcct_pkg::FRAMES_W-1:0] frames;
    logic [tcct_pkg::CUE_W-1:0]    cue_number;
    logic                         enabled;

    modport source (
        output valid, opcode, slot, hours, minutes, seconds, frames, cue_number, enabled,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, hours, minutes, seconds, frames, cue_number, enabled,
        output ready
    );
endinterface

interface tcct_out_if;
    logic                       valid;
    logic                       ready;
    logic [tcct_pkg::SLOT_W-1:0] fired_slot;
    logic [tcct_pkg::CUE_W-1:0]  fired_cue;
    logic                       last;

    modport source (
        output valid, fired_slot, fired_cue, last,
        input  ready
    );
    modport sink (
        input  valid, fired_slot, fired_cue, last,
        output ready
    );
endinterface

### src/tcct_ram.sv
module tcct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/tcct_front.sv
module tcct_front #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tcct_pkg::OP_W-1:0]     i_opcode,
    input  logic [tcct_pkg::SLOT_W-1:0]   i_slot,
    input  logic [tcct_pkg::HOURS_W-1:0]  i_hours,
    input  logic [tcct_pkg::MIN_W-1:0]    i_minutes,
    input  logic [tcct_pkg::SEC_W-1:0]    i_seconds,
    input  logic [tcct_pkg::FRAMES_W-1:0] i_frames,
    input  logic [tcct_pkg::CUE_W-1:0]    i_cue_number,
    input  logic                        i_enabled,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output tcct_pkg::t_cmd               o_cmd
);
    import tcct_pkg::*;

    localparam int QD  = 2;
    localparam int QPW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    t_cmd             r_q [QD];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_cmd.op      = t_op'(i_opcode);
        w_cmd.slot_ok = ({{(32-SLOT_W){1'b0}}, i_slot} < 32'(SLOTS));
        w_cmd.slot    = i_slot;
        w_cmd.tc      = {i_hours, i_minutes, i_seconds, i_frames};
        w_cmd.cue     = i_cue_number;
        w_cmd.enabled = i_enabled;
    end

    assign o_ready     = (r_cnt != QCW'(QD));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(w_push) - QCW'(w_pop);
        end
    end
endmodule

### src/tcct_back.sv
module tcct_back #(
    parameter int SLOTS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  tcct_pkg::t_cmd             i_cmd,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [tcct_pkg::SLOT_W-1:0] o_fired_slot,
    output logic [tcct_pkg::CUE_W-1:0]  o_fired_cue,
    output logic                      o_last
);
    import tcct_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = TIME_W + CUE_W;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [SLOTS-1:0]    r_en;
    logic [SLOTS-1:0]    r_fired;
    logic [TIME_W-1:0]   r_prev_t;
    logic                r_prev_vld;
    logic [CW-1:0]       r_rd_idx;
    logic                r_ev_vld;
    logic [IW-1:0]       r_ev_idx;
    logic                r_pend_vld;
    logic [IW-1:0]       r_pend_slot;
    logic [CUE_W-1:0]    r_pend_cue;
    logic                r_out_vld;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [CUE_W-1:0]    r_out_cue;
    logic                r_out_last;

    logic [DW-1:0]       w_rdata;
    logic [TIME_W-1:0]   w_tgt;
    logic [CUE_W-1:0]    w_cue;
    logic [IW-1:0]       w_cmd_idx;
    logic                w_idle_cmd;
    logic                w_we;
    logic                w_re;
    logic                w_act;
    logic                w_rearm;
    logic                w_fire;
    logic                w_out_free;
    logic                w_stall;
    logic                w_adv;
    logic                w_rd_more;
    logic                w_fin;

    assign w_tgt      = w_rdata[DW-1:CUE_W];
    assign w_cue      = w_rdata[CUE_W-1:0];
    assign w_cmd_idx  = IW'(i_cmd.slot);
    assign w_idle_cmd = (r_state == S_IDLE) && i_cmd_valid;
    assign w_we       = w_idle_cmd && (i_cmd.op == OP_WRITE) && i_cmd.slot_ok;

    assign w_act      = (r_state == S_SCAN) && r_ev_vld && r_en[r_ev_idx];
    assign w_rearm    = w_act && (i_cmd.tc < w_tgt);
    assign w_fire     = w_act && !w_rearm && !r_fired[r_ev_idx]
                        && (!r_prev_vld || (r_prev_t < w_tgt));
    assign w_out_free = !r_out_vld || i_ready;
    assign w_stall    = w_fire && r_pend_vld && !w_out_free;
    assign w_adv      = (r_state == S_SCAN) && !w_stall;
    assign w_rd_more  = (r_rd_idx < CW'(SLOTS));
    assign w_re       = w_adv && w_rd_more;
    assign w_fin      = (r_state == S_SCAN) && !r_ev_vld && !w_rd_more
                        && (!r_pend_vld || w_out_free);

    assign o_cmd_ready = (w_idle_cmd && (i_cmd.op != OP_TICK)) || w_fin;

    tcct_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cmd_idx),
        .i_wdata ({i_cmd.tc, i_cmd.cue}),
        .i_re    (w_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_en       <= '0;
            r_fired    <= '0;
            r_prev_t   <= '0;
            r_prev_vld <= 1'b0;
            r_rd_idx   <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.op)
                            OP_WRITE: begin
                                if (i_cmd.slot_ok) begin
                                    r_en[w_cmd_idx]    <= i_cmd.enabled;
                                    r_fired[w_cmd_idx] <= 1'b0;
                                end
                            end
                            OP_ENABLE: begin
                                if (i_cmd.slot_ok) begin
                                    r_en[w_cmd_idx] <= i_cmd.enabled;
                                end
                            end
                            OP_ARM_RESET: begin
                                r_fired    <= '0;
                                r_prev_vld <= 1'b0;
                            end
                            OP_TICK: begin
                                r_state  <= S_SCAN;
                                r_rd_idx <= '0;
                                r_ev_vld <= 1'b0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_adv) begin
                        if (w_rd_more) begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                        r_ev_vld <= w_rd_more;
                        r_ev_idx <= r_rd_idx[IW-1:0];
                        if (w_rearm) begin
                            r_fired[r_ev_idx] <= 1'b0;
                        end
                        if (w_fire) begin
                            r_fired[r_ev_idx] <= 1'b1;
                            if (r_pend_vld) begin
                                r_out_vld  <= 1'b1;
                                r_out_slot <= SLOT_W'(r_pend_slot);
                                r_out_cue  <= r_pend_cue;
                                r_out_last <= 1'b0;
                            end
                            r_pend_vld  <= 1'b1;
                            r_pend_slot <= r_ev_idx;
                            r_pend_cue  <= w_cue;
                        end
                    end
                    if (w_fin) begin
                        if (r_pend_vld) begin
                            r_out_vld  <= 1'b1;
                            r_out_slot <= SLOT_W'(r_pend_slot);
                            r_out_cue  <= r_pend_cue;
                            r_out_last <= 1'b1;
                        end
                        r_pend_vld <= 1'b0;
                        r_prev_t   <= i_cmd.tc;
                        r_prev_vld <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_valid      = r_out_vld;
    assign o_fired_slot = r_out_slot;
    assign o_fired_cue  = r_out_cue;
    assign o_last       = r_out_last;
endmodule

### src/timecode_cue_trigger_table.sv
// channel | dir | fields
// i_in    | in  | opcode, slot, hours, minutes, seconds, frames, cue_number, enabled
// o_out   | out | fired_slot, fired_cue, last
//
// Items enter a two-entry queue; write, enable and arming reset are taken straight from the idle state.
// A tick scans every slot: the slot store has one read port, one slot per cycle unless the scan stalls.
// A fired result is held back until the next fire or the end of the scan, so last can be set.
// Reset clears enables, fired flags, previous tick and queue; slot contents stay.
// Input stalls only when the queue is full; the scan stalls only on a full output.
module timecode_cue_trigger_table #(
    parameter int SLOTS = tcct_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tcct_in_if.sink        i_in,
    tcct_out_if.source     o_out
);
    import tcct_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    tcct_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_opcode     (i_in.opcode),
        .i_slot       (i_in.slot),
        .i_hours      (i_in.hours),
        .i_minutes    (i_in.minutes),
        .i_seconds    (i_in.seconds),
        .i_frames     (i_in.frames),
        .i_cue_number (i_in.cue_number),
        .i_enabled    (i_in.enabled),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    tcct_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd        (w_cmd),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_fired_slot (o_out.fired_slot),
        .o_fired_cue  (o_out.fired_cue),
        .o_last       (o_out.last)
    );
endmodule
